// ===== rtl/core/priority_counter_scheduler_assert.svh =====
// Assertion macros for the priority counter scheduler.
`ifndef PRIORITY_COUNTER_SCHEDULER_ASSERT_SVH
`define PRIORITY_COUNTER_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCS_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCS_ASSERT(name, clk, rst_n, prop, msg)
`define PCS_ASSERT_NR(name, clk, prop, msg)
`endif
`endif

// ===== rtl/core/pcs_pkg.sv =====
// Shared types and constants of the priority counter scheduler.
`default_nettype none

package pcs_pkg;

  localparam int DEF_MAX_TASKS     = 8;
  localparam int DEF_PRIORITY_BITS = 8;

  // Time-slice counter width and its saturation value
  localparam int                CNT_W       = 9;
  localparam logic [CNT_W-1:0] COUNTER_MAX = 9'd511;

  // Configuration register widths
  localparam int NTASK_W = 4;
  localparam int RMASK_W = 8;
  localparam int PTAB_W  = 64;
  localparam int CFG_IDX_W = 2;
  localparam int SEL_W   = 3;

  localparam logic [NTASK_W-1:0] NTASK_RST = 4'd2;
  localparam logic [RMASK_W-1:0] RMASK_RST = 8'd254;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_TASKS = 2'd0,
    CFG_RUNNABLE  = 2'd1,
    CFG_PRIORITY  = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_in;    // latch the tick field
    logic rd_cur;     // read the counter of the current task
    logic rd_scan;    // read counter at scan index, compare it in the next cycle
    logic rd_refill;  // read counter at scan index, refill it in the next cycle
    logic dec_wr;     // decrement the current counter, seed the result
    logic idx_last;   // load the scan index with the highest slot
    logic idx_one;    // load the scan index with slot 1
    logic idx_dec;
    logic idx_inc;
    logic best_clr;   // restart the maximum search
    logic set_rf;     // flag the result as refilled
    logic commit;     // take the scan winner as the new current task
    logic force_idle; // with commit: choose idle instead
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tick;
    logic cur_idle;
    logic dec_zero;
    logic has_slots;
    logic idx_one;
    logic idx_last;
    logic best_vld;
    logic best_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/priority_counter_scheduler.sv =====
// Top level of the priority counter scheduler: controller, datapath and checks.
`default_nettype none

`include "priority_counter_scheduler_assert.svh"

// Counter-based task scheduler. Each input transaction is one timer tick and
// produces exactly one result transaction. Every task slot owns a 9-bit
// time-slice counter; slot 0 is the idle task and is never picked by the scan.
// A tick decrements the current non-idle task's counter (saturating at zero)
// and reschedules only when it reaches zero; with idle current, every tick
// reschedules. The scan picks the runnable slot with the largest counter, the
// higher index winning ties. When all runnable counters are zero, every
// non-idle slot in use is refilled to half its counter plus its priority
// (saturating at 511) and the scan runs again; if that still gives zero, or
// nothing is runnable, idle is chosen. Counters live in a small memory with one
// registered read port and one write port, read one slot per cycle. A tick reads
// the current counter and decrements it; a reschedule adds a scan over the slots
// in use (skipped when fewer than two slots are in use), and a refill adds a
// pass over those slots and then a second scan. A stalled result channel
// holds a finished tick back until the output register is free. The
// memory's valid bits clear at reset, so no clearing pass is needed. A
// finished result sits in an output register, and the next tick is taken
// while it waits. Configuration writes are always ready and must arrive only
// while no tick is in flight; index 3 is ignored.
module priority_counter_scheduler
  import pcs_pkg::*;
#(
  parameter int MAX_TASKS     = DEF_MAX_TASKS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Tick channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 tick_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SEL_W-1:0]     selected_task_o,
  output logic                 switched_o,
  output logic                 rescheduled_o,
  output logic                 refilled_o,
  output logic [CNT_W-1:0]     slice_left_o,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PTAB_W-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  pcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcs_datapath #(
    .MAX_TASKS     (MAX_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .tick_i          (tick_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .selected_task_o (selected_task_o),
    .switched_o      (switched_o),
    .rescheduled_o   (rescheduled_o),
    .refilled_o      (refilled_o),
    .slice_left_o    (slice_left_o)
  );

  // An accepted tick closes the input side in the next cycle
  `PCS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "tick accepted while previous one in flight")
  // A task switch or refill only comes out of a scan
  `PCS_ASSERT(a_switch_needs_scan, clk_i, rst_ni, out_valid_o && (switched_o || refilled_o) |-> rescheduled_o, "switch or refill without scan")
  // Idle never carries a slice
  `PCS_ASSERT(a_idle_no_slice, clk_i, rst_ni, out_valid_o && selected_task_o == '0 |-> slice_left_o == '0, "idle reported with nonzero slice")
  // The result is loaded only when the input side is closed
  `PCS_ASSERT_NR(a_load_not_idle, clk_i, !(in_ready_o && cmd.load_out), "result loaded while ready for a tick")

endmodule

`default_nettype wire

// ===== rtl/core/pcs_ctrl.sv =====
// Sequencing state machine of the priority counter scheduler.
`default_nettype none

module pcs_ctrl
  import pcs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_DEC,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_SCAN_END,
    ST_REFILL,
    ST_REFILL_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   pass2_q, pass2_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    pass2_d     = pass2_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = ST_RD_CUR;
        end
      end
      ST_RD_CUR: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.dec_wr = 1'b1;
        if (!sts_i.tick || (!sts_i.cur_idle && !sts_i.dec_zero)) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.best_clr = 1'b1;
          pass2_d        = 1'b0;
          if (sts_i.has_slots) begin
            cmd_o.idx_last = 1'b1;
            state_d        = ST_SCAN;
          end else begin
            state_d = ST_SCAN_END;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        if (sts_i.idx_one) state_d = ST_SCAN_WAIT;
        else cmd_o.idx_dec = 1'b1;
      end
      ST_SCAN_WAIT: begin
        state_d = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (sts_i.best_vld && sts_i.best_zero && !pass2_q) begin
          cmd_o.idx_one = 1'b1;
          state_d       = ST_REFILL;
        end else begin
          cmd_o.commit     = 1'b1;
          cmd_o.force_idle = !sts_i.best_vld || sts_i.best_zero;
          state_d          = ST_FINISH;
        end
      end
      ST_REFILL: begin
        cmd_o.rd_refill = 1'b1;
        if (sts_i.idx_last) state_d = ST_REFILL_WAIT;
        else cmd_o.idx_inc = 1'b1;
      end
      ST_REFILL_WAIT: begin
        cmd_o.set_rf   = 1'b1;
        cmd_o.best_clr = 1'b1;
        cmd_o.idx_last = 1'b1;
        pass2_d        = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass2_q     <= pass2_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/pcs_datapath.sv =====
// Counter memory, configuration registers and scan datapath of the scheduler.
`default_nettype none

module pcs_datapath
  import pcs_pkg::*;
#(
  parameter int MAX_TASKS     = DEF_MAX_TASKS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 tick_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PTAB_W-1:0]    cfg_data_i,
  output logic [SEL_W-1:0]     selected_task_o,
  output logic                 switched_o,
  output logic                 rescheduled_o,
  output logic                 refilled_o,
  output logic [CNT_W-1:0]     slice_left_o
);

  localparam int TIDX_W = $clog2(MAX_TASKS);
  localparam int NCNT_W = $clog2(MAX_TASKS + 1);
  localparam int SH_W   = $clog2(MAX_TASKS * PRIORITY_BITS);
  localparam int SUM_W  = ((CNT_W > PRIORITY_BITS) ? CNT_W : PRIORITY_BITS) + 1;

  // Configuration
  logic [NTASK_W-1:0] ntasks_q;
  logic [RMASK_W-1:0] rmask_q;
  logic [PTAB_W-1:0]  ptab_q;

  // Counter memory with per-entry valid bits
  logic [CNT_W-1:0]     mem_q [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_q;
  logic [CNT_W-1:0]     mem_rd_q;
  logic                 vld_rd_q;
  logic [TIDX_W-1:0]    rd_addr_q;
  logic                 scan_pend_q;
  logic                 refill_pend_q;

  logic [TIDX_W-1:0] cur_q;
  logic [TIDX_W-1:0] idx_q;
  logic              tick_q;
  logic              best_vld_q;
  logic [CNT_W-1:0]  best_c_q;
  logic [TIDX_W-1:0] best_idx_q;

  logic [TIDX_W-1:0] res_sel_q;
  logic              res_sw_q, res_rs_q, res_rf_q;
  logic [CNT_W-1:0]  res_slice_q;

  logic [SEL_W-1:0]  out_sel_q;
  logic              out_sw_q, out_rs_q, out_rf_q;
  logic [CNT_W-1:0]  out_slice_q;

  logic [NCNT_W-1:0]        n_slots;
  logic [TIDX_W-1:0]        last_slot;
  logic                     rd_en;
  logic [TIDX_W-1:0]        rd_addr;
  logic [CNT_W-1:0]         rd_val;
  logic [CNT_W-1:0]         dec_val;
  logic                     cur_idle;
  logic                     slot_run;
  logic [SH_W-1:0]          prio_sh;
  logic [PRIORITY_BITS-1:0] prio_field;
  logic [SUM_W-1:0]         fill_sum;
  logic [CNT_W-1:0]         fill_val;
  logic                     wr_en;
  logic [TIDX_W-1:0]        wr_addr;
  logic [CNT_W-1:0]         wr_data;
  logic [TIDX_W-1:0]        pick;

  // Slots in use, clamped to the table depth
  always_comb begin
    if (32'(ntasks_q) > MAX_TASKS) n_slots = NCNT_W'(MAX_TASKS);
    else n_slots = NCNT_W'(ntasks_q);
  end
  assign last_slot = TIDX_W'(n_slots - NCNT_W'(1));

  assign rd_en   = cmd_i.rd_cur | cmd_i.rd_scan | cmd_i.rd_refill;
  assign rd_addr = cmd_i.rd_cur ? cur_q : idx_q;
  assign rd_val  = vld_rd_q ? mem_rd_q : '0;
  assign dec_val = (rd_val == '0) ? '0 : rd_val - CNT_W'(1);
  assign cur_idle = (cur_q == '0);

  // Slots past the mask width are never runnable
  assign slot_run = |(rmask_q & (RMASK_W'(1) << rd_addr_q));

  // Priority of the slot being refilled; bits past the table read as zero
  assign prio_sh    = SH_W'(rd_addr_q) * SH_W'(PRIORITY_BITS);
  assign prio_field = PRIORITY_BITS'(ptab_q >> prio_sh);
  assign fill_sum   = SUM_W'(rd_val >> 1) + SUM_W'(prio_field);
  assign fill_val   = (fill_sum > SUM_W'(COUNTER_MAX)) ? COUNTER_MAX : CNT_W'(fill_sum);

  assign wr_en   = (cmd_i.dec_wr & tick_q & ~cur_idle) | refill_pend_q;
  assign wr_addr = refill_pend_q ? rd_addr_q : cur_q;
  assign wr_data = refill_pend_q ? fill_val : dec_val;

  assign pick = cmd_i.force_idle ? '0 : best_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      mem_rd_q  <= mem_q[rd_addr];
      vld_rd_q  <= vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= '0;
      ntasks_q      <= NTASK_RST;
      rmask_q       <= RMASK_RST;
      ptab_q        <= '0;
      cur_q         <= '0;
      best_vld_q    <= 1'b0;
      scan_pend_q   <= 1'b0;
      refill_pend_q <= 1'b0;
    end else begin
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_NUM_TASKS: ntasks_q <= cfg_data_i[NTASK_W-1:0];
          CFG_RUNNABLE:  rmask_q  <= cfg_data_i[RMASK_W-1:0];
          CFG_PRIORITY:  ptab_q   <= cfg_data_i;
          default: ;
        endcase
      end
      scan_pend_q   <= cmd_i.rd_scan;
      refill_pend_q <= cmd_i.rd_refill;
      if (cmd_i.best_clr) begin
        best_vld_q <= 1'b0;
      end else if (scan_pend_q && slot_run && (!best_vld_q || rd_val > best_c_q)) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.commit) cur_q <= pick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) tick_q <= tick_i;
    if (cmd_i.idx_last) idx_q <= last_slot;
    else if (cmd_i.idx_one) idx_q <= TIDX_W'(1);
    else if (cmd_i.idx_dec) idx_q <= idx_q - TIDX_W'(1);
    else if (cmd_i.idx_inc) idx_q <= idx_q + TIDX_W'(1);
    // Strictly greater keeps the higher index on ties, since the scan runs downward
    if (scan_pend_q && slot_run && (!best_vld_q || rd_val > best_c_q)) begin
      best_c_q   <= rd_val;
      best_idx_q <= rd_addr_q;
    end
    if (cmd_i.dec_wr) begin
      res_sel_q   <= cur_q;
      res_sw_q    <= 1'b0;
      res_rs_q    <= 1'b0;
      res_rf_q    <= 1'b0;
      res_slice_q <= (tick_q && !cur_idle) ? dec_val : rd_val;
    end
    if (cmd_i.set_rf) res_rf_q <= 1'b1;
    if (cmd_i.commit) begin
      res_sel_q   <= pick;
      res_sw_q    <= (pick != cur_q);
      res_rs_q    <= 1'b1;
      res_slice_q <= cmd_i.force_idle ? '0 : best_c_q;
    end
    if (cmd_i.load_out) begin
      out_sel_q   <= SEL_W'(res_sel_q);
      out_sw_q    <= res_sw_q;
      out_rs_q    <= res_rs_q;
      out_rf_q    <= res_rf_q;
      out_slice_q <= res_slice_q;
    end
  end

  always_comb begin
    sts_o.tick      = tick_q;
    sts_o.cur_idle  = cur_idle;
    sts_o.dec_zero  = (dec_val == '0);
    sts_o.has_slots = (n_slots > NCNT_W'(1));
    sts_o.idx_one   = (idx_q == TIDX_W'(1));
    sts_o.idx_last  = (idx_q == last_slot);
    sts_o.best_vld  = best_vld_q;
    sts_o.best_zero = (best_c_q == '0);
  end

  assign selected_task_o = out_sel_q;
  assign switched_o      = out_sw_q;
  assign rescheduled_o   = out_rs_q;
  assign refilled_o      = out_rf_q;
  assign slice_left_o    = out_slice_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the priority counter scheduler.

module tb_top;
  import pcs_pkg::*;

  // Index 3 has no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;

  localparam int N_SLOTS      = DEF_MAX_TASKS;
  localparam int PRIO_W       = DEF_PRIORITY_BITS;
  localparam int RANDOM_TICKS = 1350;
  localparam int STEADY_TICKS = 150;
  localparam int TAIL_CYCLES  = 40;
  localparam int REPORT_LIMIT = 10;

  // One scheduling decision as the result channel reports it
  typedef struct packed {
    logic [SEL_W-1:0] slot;
    logic             switched;
    logic             resched;
    logic             refill;
    logic [CNT_W-1:0] left;
  } pick_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 tick_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SEL_W-1:0]     selected_task_o;
  logic                 switched_o;
  logic                 rescheduled_o;
  logic                 refilled_o;
  logic [CNT_W-1:0]     slice_left_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [PTAB_W-1:0]    cfg_data_i;

  priority_counter_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .tick_i          (tick_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .selected_task_o (selected_task_o),
    .switched_o      (switched_o),
    .rescheduled_o   (rescheduled_o),
    .refilled_o      (refilled_o),
    .slice_left_o    (slice_left_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Mirror of the scheduler state and its registers, updated as ticks are accepted
  logic [SEL_W-1:0]   run_slot;
  logic [CNT_W-1:0]   slice_cnt [N_SLOTS];
  logic [NTASK_W-1:0] num_tasks;
  logic [RMASK_W-1:0] ready_mask;
  logic [PTAB_W-1:0]  prio_table;

  // Decisions predicted for accepted ticks, oldest first
  pick_t predicted_picks[$];
  int    mismatches;

  // Random idling switches for the tick sender and the result receiver
  bit gaps_on;
  bit stalls_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Slot counts above the table depth behave as a full table.
  function automatic int slots_used();
    return (num_tasks > N_SLOTS) ? N_SLOTS : int'(num_tasks);
  endfunction

  // Find the runnable slot with the largest counter, the highest index winning
  // ties; best_cnt is -1 when no slot in use is runnable. Idle is never a candidate.
  function automatic int best_slot(output int best_cnt);
    int pick;
    pick     = 0;
    best_cnt = -1;
    for (int i = slots_used() - 1; i >= 1; i--) begin
      if (ready_mask[i] && int'(slice_cnt[i]) > best_cnt) begin
        best_cnt = int'(slice_cnt[i]);
        pick     = i;
      end
    end
    return pick;
  endfunction

  // Advance the mirrored state by one tick transaction and return the decision.
  function automatic pick_t schedule_tick(input logic tick);
    int    prev;
    int    sel;
    int    best;
    int    n;
    int    refreshed;
    logic  do_scan;
    pick_t r;
    prev = int'(run_slot);
    sel  = prev;
    r    = '0;
    if (tick) begin
      do_scan = 1'b1;
      // Charge the running task; only an exhausted slice forces a new pick.
      if (prev != 0) begin
        if (slice_cnt[prev] != 0) slice_cnt[prev] = slice_cnt[prev] - 1'b1;
        do_scan = (slice_cnt[prev] == 0);
      end
      if (do_scan) begin
        r.resched = 1'b1;
        sel = best_slot(best);
        // Every runnable slice is spent: age every non-idle slot in use and rescan once.
        if (best == 0) begin
          r.refill = 1'b1;
          n = slots_used();
          for (int s = 1; s < n; s++) begin
            refreshed = int'(slice_cnt[s] >> 1) + int'(prio_table[s*PRIO_W +: PRIO_W]);
            slice_cnt[s] = (refreshed > int'(COUNTER_MAX)) ? COUNTER_MAX
                                                           : refreshed[CNT_W-1:0];
          end
          sel = best_slot(best);
          // All priorities zero: fall back to idle rather than spin.
          if (best <= 0) sel = 0;
        end
        run_slot = sel[SEL_W-1:0];
      end
    end
    r.slot     = sel[SEL_W-1:0];
    r.switched = (sel != prev);
    r.left     = slice_cnt[sel];
    return r;
  endfunction

  // Offer one tick transaction, with a random gap ahead of it when gaps are on.
  // Valid stays high after acceptance so back-to-back ticks need no extra edge.
  task automatic send_tick(input logic tick);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_picks.push_back(schedule_tick(tick));
  endtask

  // Drive one register write and hold it until taken; the caller drops valid.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PTAB_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NUM_TASKS: num_tasks  = data[NTASK_W-1:0];
      CFG_RUNNABLE:  ready_mask = data[RMASK_W-1:0];
      CFG_PRIORITY:  prio_table = data;
      default: ;
    endcase
  endtask

  // Stop sending, wait for every pending decision, then write the selected
  // registers (bit 3 of which hits the reserved index). Unused upper data bits
  // carry noise, since the block must ignore them.
  task automatic configure(input bit [3:0] which, input logic [NTASK_W-1:0] nt,
                           input logic [RMASK_W-1:0] rm, input logic [PTAB_W-1:0] pt);
    logic [PTAB_W-1:0] noise;
    in_valid_i <= 1'b0;
    while (predicted_picks.size() != 0) @(posedge clk_i);
    noise = {$urandom, $urandom};
    if (which[0]) write_reg(CFG_NUM_TASKS, {noise[PTAB_W-1:NTASK_W], nt});
    if (which[1]) write_reg(CFG_RUNNABLE, {noise[PTAB_W-1:RMASK_W], rm});
    if (which[2]) write_reg(CFG_PRIORITY, pt);
    if (which[3]) write_reg(CFG_RESERVED, noise);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset registers: one runnable slot with priority zero, so a refill leaves
  // everything spent and idle is picked. A zero tick must change nothing.
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Single task with a two-tick slice: count down, refill, keep the same slot.
  task automatic test_single_slot();
    configure(4'b0111, 4'd2, 8'hFE, 64'h0000_0000_0000_0200);
    repeat (4) send_tick(1'b1);
  endtask

  // No runnable slot at all, then only the idle bit set: idle without a refill.
  task automatic test_nothing_runnable();
    configure(4'b0010, 4'd0, 8'h00, 64'd0);
    repeat (2) send_tick(1'b1);
    configure(4'b0010, 4'd0, 8'h01, 64'd0);
    send_tick(1'b1);
  endtask

  // Slot counts 0 and 1 leave nothing to pick; 15 acts as a full table and,
  // with maximum priorities, refills every slot and picks the top index.
  task automatic test_count_extremes();
    configure(4'b0011, 4'd0, 8'hFF, 64'd0);
    send_tick(1'b1);
    configure(4'b0001, 4'd1, 8'hFF, 64'd0);
    send_tick(1'b1);
    configure(4'b0101, 4'd15, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Shrink the table below the running slot: it keeps running and paying.
  task automatic test_running_outside_count();
    configure(4'b0001, 4'd2, 8'hFF, 64'd0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // A write to the reserved index must leave every register alone.
  task automatic test_reserved_index();
    configure(4'b1000, 4'd0, 8'd0, 64'd0);
    send_tick(1'b1);
  endtask

  // Random register settings, mostly small priorities so slices run out often.
  task automatic random_config(input bit [3:0] which);
    logic [NTASK_W-1:0] nt;
    logic [RMASK_W-1:0] rm;
    logic [PTAB_W-1:0]  pt;
    case ($urandom_range(0, 9))
      0:       nt = NTASK_W'($urandom_range(0, 1));
      1:       nt = NTASK_W'($urandom_range(9, 15));
      default: nt = NTASK_W'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       rm = 8'h00;
      1:       rm = 8'hFF;
      default: rm = RMASK_W'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      pt = {$urandom, $urandom};
    end else begin
      for (int b = 0; b < N_SLOTS; b++) begin
        case ($urandom_range(0, 7))
          0:       pt[b*PRIO_W +: PRIO_W] = '0;
          1:       pt[b*PRIO_W +: PRIO_W] = PRIO_W'($urandom_range(0, 255));
          default: pt[b*PRIO_W +: PRIO_W] = PRIO_W'($urandom_range(1, 5));
        endcase
      end
    end
    configure(which, nt, rm, pt);
  endtask

  // Bursts of ticks under changing settings and idling; about one in ten is a zero tick.
  task automatic test_random_phases();
    int sent;
    int len;
    sent = 0;
    while (sent < RANDOM_TICKS - STEADY_TICKS) begin
      random_config(4'($urandom_range(1, 15)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(20, 60);
      repeat (len) send_tick($urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    random_config(4'b0111);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (STEADY_TICKS) send_tick($urandom_range(0, 9) != 0);
  endtask

  // Result receiver: hold ready low for random bursts while stalls are on.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Compare every result transaction against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    pick_t got;
    pick_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.slot     = selected_task_o;
      got.switched = switched_o;
      got.resched  = rescheduled_o;
      got.refill   = refilled_o;
      got.left     = slice_left_o;
      if (predicted_picks.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("Unexpected result: slot %0d sw %0b resched %0b refill %0b left %0d",
                   got.slot, got.switched, got.resched, got.refill, got.left);
        mismatches++;
      end else begin
        want = predicted_picks.pop_front();
        if (got.slot !== want.slot || got.switched !== want.switched ||
            got.resched !== want.resched || got.refill !== want.refill ||
            got.left !== want.left) begin
          if (mismatches < REPORT_LIMIT)
            $display("Result mismatch: want slot %0d sw %0b resched %0b refill %0b left %0d, %s",
                     want.slot, want.switched, want.resched, want.refill, want.left,
                     $sformatf("got slot %0d sw %0b resched %0b refill %0b left %0d",
                               got.slot, got.switched, got.resched, got.refill, got.left));
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    tick_i      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_NUM_TASKS;
    cfg_data_i  <= '0;
    // Start the mirror from the reset state of the block.
    run_slot   = '0;
    num_tasks  = NTASK_RST;
    ready_mask = RMASK_RST;
    prio_table = '0;
    foreach (slice_cnt[i]) slice_cnt[i] = '0;
    mismatches = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_single_slot();
    test_nothing_runnable();
    test_count_extremes();
    test_running_outside_count();
    test_reserved_index();
    test_random_phases();
    test_steady_stream();

    // Drain, then give a stray extra result time to show up.
    in_valid_i <= 1'b0;
    while (predicted_picks.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && predicted_picks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
